### rtl/core/ptint_pkg.sv
// Shared types, constants and arithmetic helpers for the particle table integrator.
// No dependencies; the files that use it refer to it by scoped names.
package ptint_pkg;

  localparam int unsigned MaxParticles = 64;
  localparam int unsigned IdxW = $clog2(MaxParticles);
  localparam int unsigned CntW = $clog2(MaxParticles + 1);

  typedef enum logic [1:0] {
    MODE_SPAWN = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_DROP  = 2'd1,
    ST_REC   = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Operand select of the shared multiplier.
  typedef enum logic [3:0] {
    OP_FX, OP_FY, OP_VX, OP_VY, OP_SZ, OP_C0, OP_C1, OP_C2, OP_C3, OP_COS, OP_SIN
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP,
    S_SP_TRIG, S_SP_MUL, S_SP_ACC, S_SP_DIV, S_SP_DWAIT, S_SP_WR,
    S_TK_FMUL, S_TK_FACC, S_TK_SCAN, S_TK_SWAIT, S_TK_MRD, S_TK_MWAIT, S_TK_PICK,
    S_TK_RD, S_TK_RWAIT, S_TK_PRE, S_TK_MUL, S_TK_ACC, S_TK_WB
  } state_e;

  localparam logic [2:0] DivLast = 3'd4;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic signed [16:0] life;
    logic signed [23:0] size;
    logic signed [23:0] size_rate;
    logic [3:0][15:0]   color;       // [0] red .. [3] alpha, Q8.8
    logic [3:0][15:0]   color_rate;  // signed Q4.12
  } particle_t;

  typedef struct packed {
    logic    cap;
    logic    trig;
    logic    op_ld;
    op_e     op_val;
    logic    op_inc;
    logic    mul;
    logic    acc;
    logic    div_go;
    logic    div_store;
    logic    ld_rec;
    logic    tick_pre;
    logic    i_clr;
    logic    i_inc;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    rd_cnt;
    logic    we_rec;
    logic    we_spawn;
    logic    we_move;
    logic    emit;
    status_e emit_status;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  full;
    logic  cnt_zero;
    logic  i_ge_cnt;
    logic  rd_neg;
    op_e   op;
    logic  div_done;
    logic  div_last;
    logic  rec_last;
  } dp_stat_t;

  typedef logic [14:0] sin_tab_t [0:90];

  // Q1.14 sine for 0..90 degrees, built by 1 degree rotations of a Q2.30 vector.
  function automatic sin_tab_t sin_tab_f();
    sin_tab_t t;
    longint c, s, nc, ns, r;
    int d;
    c = 64'sd1 <<< 30;
    s = 64'sd0;
    for (d = 0; d <= 90; d++) begin
      r = (s + 64'sd32768) >>> 16;
      if (r < 0) r = 0;
      else if (r > 16384) r = 16384;
      t[d] = 15'(r);
      nc = c * 64'sd1073578288 - s * 64'sd18739379;
      ns = s * 64'sd1073578288 + c * 64'sd18739379;
      c = (nc + (64'sd1 <<< 29)) >>> 30;
      s = (ns + (64'sd1 <<< 29)) >>> 30;
    end
    return t;
  endfunction

  localparam sin_tab_t SinTab = sin_tab_f();

  function automatic logic signed [15:0] sin_deg(input logic [8:0] a);
    logic [8:0]  i;
    logic        neg;
    logic [15:0] mag;
    neg = 1'b0;
    if (a <= 9'd90) i = a;
    else if (a <= 9'd180) i = 9'd180 - a;
    else if (a <= 9'd270) begin
      i = a - 9'd180;
      neg = 1'b1;
    end else begin
      i = 9'd360 - a;
      neg = 1'b1;
    end
    mag = {1'b0, SinTab[i[6:0]]};
    return neg ? -mag : mag;
  endfunction

  function automatic logic [23:0] sat24(input logic signed [43:0] v);
    logic [23:0] r;
    if (v > 44'sd8388607) r = 24'h7FFFFF;
    else if (v < -44'sd8388608) r = 24'h800000;
    else r = v[23:0];
    return r;
  endfunction

  function automatic logic [16:0] sat17(input logic signed [43:0] v);
    logic [16:0] r;
    if (v > 44'sd65535) r = 17'h0FFFF;
    else if (v < -44'sd65536) r = 17'h10000;
    else r = v[16:0];
    return r;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [43:0] v);
    logic [15:0] r;
    if (v > 44'sd32767) r = 16'h7FFF;
    else if (v < -44'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic [15:0] clamp_col(input logic [15:0] col,
                                            input logic signed [43:0] d);
    logic signed [43:0] s;
    logic [15:0] r;
    s = $signed({28'd0, col}) + d;
    if (s < 0) r = 16'h0000;
    else if (s > 44'sd65280) r = 16'hFF00;
    else r = s[15:0];
    return r;
  endfunction

  // whole pixels, truncated toward zero
  function automatic logic [15:0] trunc_px(input logic signed [23:0] p);
    logic [23:0] m;
    logic [15:0] w;
    m = p[23] ? -p : p;
    w = m[23:8];
    return p[23] ? -w : w;
  endfunction

  function automatic logic [7:0] size_px(input logic signed [23:0] s);
    logic [7:0] r;
    if (s[23]) r = 8'd0;
    else if (s[22:16] != 7'd0) r = 8'hFF;
    else r = s[15:8];
    return r;
  endfunction

endpackage

### rtl/core/ptint_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptint_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/ptint_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, sign applied at the end.
// Depends on nothing but its ports.
module ptint_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [23:0]        num_i,
  input  logic [15:0]        den_i,
  input  logic               neg_i,
  output logic               done_o,
  output logic signed [24:0] quo_o
);

  logic [4:0]  cnt_q;
  logic [15:0] rem_q, rem_d;
  logic [23:0] quo_q;
  logic        neg_q, done_q, ge;
  logic [16:0] trial;

  always_comb begin
    trial = {rem_q, quo_q[23]};
    ge    = trial >= {1'b0, den_i};
    rem_d = ge ? 16'(trial - {1'b0, den_i}) : trial[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= 5'd24;
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 5'd1;
      done_q <= (cnt_q == 5'd1);
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      neg_q <= neg_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[22:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

### rtl/core/ptint_dp.sv
// Datapath: particle RAM, working record, shared multiplier, divider, counters.
// Uses ptint_pkg, ptint_ram, ptint_div; driven by ptint_ctrl commands.
module ptint_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ptint_pkg::ctrl_cmd_t     cmd_i,
  output ptint_pkg::dp_stat_t      stat_o,
  input  logic [1:0]               mode_i,
  input  logic signed [23:0]       start_x_i,
  input  logic signed [23:0]       start_y_i,
  input  logic [15:0]              lifetime_i,
  input  logic [8:0]               heading_degrees_i,
  input  logic [15:0]              launch_speed_i,
  input  logic [15:0]              size_start_i,
  input  logic [15:0]              size_finish_i,
  input  logic [31:0]              rgba_start_i,
  input  logic [31:0]              rgba_finish_i,
  input  logic [15:0]              time_step_i,
  input  logic signed [15:0]       force_x_i,
  input  logic signed [15:0]       force_y_i,
  output logic                     res_valid_o,
  output logic [1:0]               status_o,
  output logic signed [15:0]       out_x_o,
  output logic signed [15:0]       out_y_o,
  output logic [7:0]               out_size_o,
  output logic [31:0]              out_rgba_o,
  output logic                     last_o
);

  // captured item
  ptint_pkg::mode_e   mode_q;
  logic signed [23:0] sx_q, sy_q;
  logic [15:0]        life_q, speed_q, s0_q, s1_q, dt_q;
  logic [8:0]         hdg_q;
  logic [31:0]        rgba0_q, rgba1_q;

  ptint_pkg::particle_t rec_q, rdata;
  ptint_pkg::op_e       op_q;
  logic [ptint_pkg::CntW-1:0] cnt_q, i_q;
  logic [2:0]         div_idx_q;
  logic signed [15:0] cos_q, nsin_q;
  logic signed [27:0] fdx_q, fdy_q;
  logic signed [41:0] prod_q;
  logic signed [24:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [43:0] p4, p8, p10;

  logic [8:0] ang, cang_raw, cang;

  // result registers
  logic        valid_q, last_q;
  logic [1:0]  status_q;
  logic [15:0] ox_q, oy_q;
  logic [7:0]  osz_q;
  logic [31:0] orgba_q;

  // divider hookup
  logic signed [16:0] sdiff;
  logic signed [8:0]  cdiff;
  logic [15:0]        sabs;
  logic [7:0]         cabs;
  logic [23:0]        div_num;
  logic               div_neg, div_done;
  logic [15:0]        div_den;
  logic signed [24:0] div_quo;

  logic                         ram_we;
  logic [ptint_pkg::IdxW-1:0]   ram_waddr, ram_raddr;
  ptint_pkg::particle_t         ram_wdata;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      mode_q  <= ptint_pkg::mode_e'(mode_i);
      sx_q    <= start_x_i;
      sy_q    <= start_y_i;
      life_q  <= lifetime_i;
      hdg_q   <= heading_degrees_i;
      speed_q <= launch_speed_i;
      s0_q    <= size_start_i;
      s1_q    <= size_finish_i;
      rgba0_q <= rgba_start_i;
      rgba1_q <= rgba_finish_i;
      dt_q    <= time_step_i;
    end
  end

  // heading mod 360, cosine as sine of heading + 90
  always_comb begin
    ang      = (hdg_q >= 9'd360) ? hdg_q - 9'd360 : hdg_q;
    cang_raw = ang + 9'd90;
    cang     = (cang_raw >= 9'd360) ? cang_raw - 9'd360 : cang_raw;
  end

  // shared multiplier operands
  always_comb begin
    unique case (op_q)
      ptint_pkg::OP_FX:  mul_a = 25'(force_x_i);
      ptint_pkg::OP_FY:  mul_a = 25'(force_y_i);
      ptint_pkg::OP_VX:  mul_a = 25'(rec_q.vel_x);
      ptint_pkg::OP_VY:  mul_a = 25'(rec_q.vel_y);
      ptint_pkg::OP_SZ:  mul_a = 25'(rec_q.size_rate);
      ptint_pkg::OP_C0:  mul_a = 25'($signed(rec_q.color_rate[0]));
      ptint_pkg::OP_C1:  mul_a = 25'($signed(rec_q.color_rate[1]));
      ptint_pkg::OP_C2:  mul_a = 25'($signed(rec_q.color_rate[2]));
      ptint_pkg::OP_C3:  mul_a = 25'($signed(rec_q.color_rate[3]));
      ptint_pkg::OP_COS: mul_a = 25'(cos_q);
      ptint_pkg::OP_SIN: mul_a = 25'(nsin_q);
      default:           mul_a = '0;
    endcase
    mul_b = (op_q == ptint_pkg::OP_COS || op_q == ptint_pkg::OP_SIN) ?
            $signed({1'b0, speed_q}) : $signed({1'b0, dt_q});
    p4  = 44'(prod_q) >>> 4;
    p8  = 44'(prod_q) >>> 8;
    p10 = 44'(prod_q) >>> 10;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) prod_q <= mul_a * mul_b;
  end

  // rate numerators: size uses Q8 scaling, color channels Q12
  always_comb begin
    sdiff = $signed({1'b0, s1_q}) - $signed({1'b0, s0_q});
    unique case (div_idx_q)
      3'd1:    cdiff = $signed({1'b0, rgba1_q[31:24]}) - $signed({1'b0, rgba0_q[31:24]});
      3'd2:    cdiff = $signed({1'b0, rgba1_q[23:16]}) - $signed({1'b0, rgba0_q[23:16]});
      3'd3:    cdiff = $signed({1'b0, rgba1_q[15:8]})  - $signed({1'b0, rgba0_q[15:8]});
      default: cdiff = $signed({1'b0, rgba1_q[7:0]})   - $signed({1'b0, rgba0_q[7:0]});
    endcase
    sabs = sdiff[16] ? 16'(-sdiff) : sdiff[15:0];
    cabs = cdiff[8] ? 8'(-cdiff) : cdiff[7:0];
    if (div_idx_q == 3'd0) begin
      div_num = {sabs, 8'd0};
      div_neg = sdiff[16];
    end else begin
      div_num = {4'd0, cabs, 12'd0};
      div_neg = cdiff[8];
    end
    div_den = (life_q == 16'd0) ? 16'd1 : life_q;
  end

  ptint_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (cmd_i.div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .neg_i   (div_neg),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // working record
  always_ff @(posedge clk_i) begin
    if (cmd_i.trig) begin
      rec_q.pos_x    <= sx_q;
      rec_q.pos_y    <= sy_q;
      rec_q.life     <= $signed({1'b0, life_q});
      rec_q.size     <= $signed({8'd0, s0_q});
      rec_q.color[0] <= {rgba0_q[31:24], 8'd0};
      rec_q.color[1] <= {rgba0_q[23:16], 8'd0};
      rec_q.color[2] <= {rgba0_q[15:8], 8'd0};
      rec_q.color[3] <= {rgba0_q[7:0], 8'd0};
      cos_q          <= ptint_pkg::sin_deg(cang);
      nsin_q         <= -ptint_pkg::sin_deg(ang);
    end
    if (cmd_i.ld_rec) rec_q <= rdata;
    if (cmd_i.tick_pre) begin
      rec_q.vel_x <= ptint_pkg::sat24(44'(rec_q.vel_x) + 44'(fdx_q));
      rec_q.vel_y <= ptint_pkg::sat24(44'(rec_q.vel_y) + 44'(fdy_q));
      rec_q.life  <= ptint_pkg::sat17(44'(rec_q.life) - $signed({28'd0, dt_q}));
    end
    if (cmd_i.acc) begin
      unique case (op_q)
        ptint_pkg::OP_FX:  fdx_q <= p4[27:0];
        ptint_pkg::OP_FY:  fdy_q <= p4[27:0];
        ptint_pkg::OP_VX:  rec_q.pos_x <= ptint_pkg::sat24(44'(rec_q.pos_x) + p8);
        ptint_pkg::OP_VY:  rec_q.pos_y <= ptint_pkg::sat24(44'(rec_q.pos_y) + p8);
        ptint_pkg::OP_SZ:  rec_q.size  <= ptint_pkg::sat24(44'(rec_q.size) + p8);
        ptint_pkg::OP_C0:  rec_q.color[0] <= ptint_pkg::clamp_col(rec_q.color[0], p4);
        ptint_pkg::OP_C1:  rec_q.color[1] <= ptint_pkg::clamp_col(rec_q.color[1], p4);
        ptint_pkg::OP_C2:  rec_q.color[2] <= ptint_pkg::clamp_col(rec_q.color[2], p4);
        ptint_pkg::OP_C3:  rec_q.color[3] <= ptint_pkg::clamp_col(rec_q.color[3], p4);
        ptint_pkg::OP_COS: rec_q.vel_x <= ptint_pkg::sat24(p10);
        ptint_pkg::OP_SIN: rec_q.vel_y <= ptint_pkg::sat24(p10);
        default: ;
      endcase
    end
    if (cmd_i.div_store) begin
      unique case (div_idx_q)
        3'd0:    rec_q.size_rate     <= ptint_pkg::sat24(44'(div_quo));
        3'd1:    rec_q.color_rate[0] <= ptint_pkg::sat16(44'(div_quo));
        3'd2:    rec_q.color_rate[1] <= ptint_pkg::sat16(44'(div_quo));
        3'd3:    rec_q.color_rate[2] <= ptint_pkg::sat16(44'(div_quo));
        default: rec_q.color_rate[3] <= ptint_pkg::sat16(44'(div_quo));
      endcase
    end
  end

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      i_q       <= '0;
      op_q      <= ptint_pkg::OP_FX;
      div_idx_q <= '0;
    end else begin
      if (cmd_i.cnt_clr) cnt_q <= '0;
      else if (cmd_i.cnt_inc) cnt_q <= cnt_q + 1'b1;
      else if (cmd_i.cnt_dec) cnt_q <= cnt_q - 1'b1;
      if (cmd_i.i_clr) i_q <= '0;
      else if (cmd_i.i_inc) i_q <= i_q + 1'b1;
      if (cmd_i.op_ld) op_q <= cmd_i.op_val;
      else if (cmd_i.op_inc) op_q <= ptint_pkg::op_e'(op_q + 4'd1);
      if (cmd_i.trig) div_idx_q <= '0;
      else if (cmd_i.div_store) div_idx_q <= div_idx_q + 3'd1;
    end
  end

  // particle store
  assign ram_we    = cmd_i.we_rec || cmd_i.we_move;
  assign ram_waddr = cmd_i.we_spawn ? cnt_q[ptint_pkg::IdxW-1:0] : i_q[ptint_pkg::IdxW-1:0];
  assign ram_wdata = cmd_i.we_move ? rdata : rec_q;
  assign ram_raddr = cmd_i.rd_cnt ? cnt_q[ptint_pkg::IdxW-1:0] : i_q[ptint_pkg::IdxW-1:0];

  ptint_ram #(
    .Width ($bits(ptint_pkg::particle_t)),
    .Depth (ptint_pkg::MaxParticles)
  ) u_ram (
    .clk_i,
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= cmd_i.emit;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q <= cmd_i.emit_status;
      if (cmd_i.emit_status == ptint_pkg::ST_REC) begin
        ox_q    <= ptint_pkg::trunc_px(rec_q.pos_x);
        oy_q    <= ptint_pkg::trunc_px(rec_q.pos_y);
        osz_q   <= ptint_pkg::size_px(rec_q.size);
        orgba_q <= {rec_q.color[0][15:8], rec_q.color[1][15:8],
                    rec_q.color[2][15:8], rec_q.color[3][15:8]};
        last_q  <= stat_o.rec_last;
      end else begin
        ox_q    <= '0;
        oy_q    <= '0;
        osz_q   <= '0;
        orgba_q <= '0;
        last_q  <= 1'b1;
      end
    end
  end

  assign res_valid_o = valid_q;
  assign status_o    = status_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_size_o  = osz_q;
  assign out_rgba_o  = orgba_q;
  assign last_o      = last_q;

  always_comb begin
    stat_o.mode     = mode_q;
    stat_o.full     = (cnt_q == ptint_pkg::CntW'(ptint_pkg::MaxParticles));
    stat_o.cnt_zero = (cnt_q == '0);
    stat_o.i_ge_cnt = (i_q >= cnt_q);
    stat_o.rd_neg   = rdata.life[16];
    stat_o.op       = op_q;
    stat_o.div_done = div_done;
    stat_o.div_last = (div_idx_q == ptint_pkg::DivLast);
    stat_o.rec_last = (i_q + 1'b1 == cnt_q);
  end

endmodule

### rtl/core/ptint_ctrl.sv
// Controller FSM: sequences spawn, tick and clear over the datapath.
// Uses ptint_pkg command/status types.
module ptint_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  ptint_pkg::dp_stat_t  stat_i,
  output ptint_pkg::ctrl_cmd_t cmd_o,
  output logic                 busy_o
);

  ptint_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ptint_pkg::S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptint_pkg::S_IDLE: if (start_i) state_d = ptint_pkg::S_DISP;
      ptint_pkg::S_DISP: begin
        unique case (stat_i.mode)
          ptint_pkg::MODE_SPAWN:
            state_d = stat_i.full ? ptint_pkg::S_IDLE : ptint_pkg::S_SP_TRIG;
          ptint_pkg::MODE_TICK: state_d = ptint_pkg::S_TK_FMUL;
          default: state_d = ptint_pkg::S_IDLE;
        endcase
      end
      ptint_pkg::S_SP_TRIG:  state_d = ptint_pkg::S_SP_MUL;
      ptint_pkg::S_SP_MUL:   state_d = ptint_pkg::S_SP_ACC;
      ptint_pkg::S_SP_ACC:
        state_d = (stat_i.op == ptint_pkg::OP_SIN) ? ptint_pkg::S_SP_DIV : ptint_pkg::S_SP_MUL;
      ptint_pkg::S_SP_DIV:   state_d = ptint_pkg::S_SP_DWAIT;
      ptint_pkg::S_SP_DWAIT:
        if (stat_i.div_done)
          state_d = stat_i.div_last ? ptint_pkg::S_SP_WR : ptint_pkg::S_SP_DIV;
      ptint_pkg::S_SP_WR:    state_d = ptint_pkg::S_IDLE;
      ptint_pkg::S_TK_FMUL:  state_d = ptint_pkg::S_TK_FACC;
      ptint_pkg::S_TK_FACC:
        state_d = (stat_i.op == ptint_pkg::OP_FY) ? ptint_pkg::S_TK_SCAN : ptint_pkg::S_TK_FMUL;
      ptint_pkg::S_TK_SCAN:
        state_d = stat_i.i_ge_cnt ? ptint_pkg::S_TK_PICK : ptint_pkg::S_TK_SWAIT;
      ptint_pkg::S_TK_SWAIT:
        state_d = stat_i.rd_neg ? ptint_pkg::S_TK_MRD : ptint_pkg::S_TK_SCAN;
      ptint_pkg::S_TK_MRD:   state_d = ptint_pkg::S_TK_MWAIT;
      ptint_pkg::S_TK_MWAIT: state_d = ptint_pkg::S_TK_SCAN;
      ptint_pkg::S_TK_PICK:
        state_d = stat_i.cnt_zero ? ptint_pkg::S_IDLE : ptint_pkg::S_TK_RD;
      ptint_pkg::S_TK_RD:    state_d = ptint_pkg::S_TK_RWAIT;
      ptint_pkg::S_TK_RWAIT: state_d = ptint_pkg::S_TK_PRE;
      ptint_pkg::S_TK_PRE:   state_d = ptint_pkg::S_TK_MUL;
      ptint_pkg::S_TK_MUL:   state_d = ptint_pkg::S_TK_ACC;
      ptint_pkg::S_TK_ACC:
        state_d = (stat_i.op == ptint_pkg::OP_C3) ? ptint_pkg::S_TK_WB : ptint_pkg::S_TK_MUL;
      ptint_pkg::S_TK_WB:
        state_d = stat_i.rec_last ? ptint_pkg::S_IDLE : ptint_pkg::S_TK_RD;
      default: state_d = ptint_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ptint_pkg::S_IDLE: cmd_o.cap = start_i;
      ptint_pkg::S_DISP: begin
        unique case (stat_i.mode)
          ptint_pkg::MODE_SPAWN: begin
            cmd_o.op_ld  = 1'b1;
            cmd_o.op_val = ptint_pkg::OP_COS;
            if (stat_i.full) begin
              cmd_o.emit        = 1'b1;
              cmd_o.emit_status = ptint_pkg::ST_DROP;
            end
          end
          ptint_pkg::MODE_TICK: begin
            cmd_o.op_ld  = 1'b1;
            cmd_o.op_val = ptint_pkg::OP_FX;
          end
          ptint_pkg::MODE_CLEAR: begin
            cmd_o.cnt_clr     = 1'b1;
            cmd_o.emit        = 1'b1;
            cmd_o.emit_status = ptint_pkg::ST_DONE;
          end
          default: ;
        endcase
      end
      ptint_pkg::S_SP_TRIG: cmd_o.trig = 1'b1;
      ptint_pkg::S_SP_MUL, ptint_pkg::S_TK_FMUL, ptint_pkg::S_TK_MUL: cmd_o.mul = 1'b1;
      ptint_pkg::S_SP_ACC, ptint_pkg::S_TK_ACC: begin
        cmd_o.acc    = 1'b1;
        cmd_o.op_inc = 1'b1;
      end
      ptint_pkg::S_SP_DIV:   cmd_o.div_go = 1'b1;
      ptint_pkg::S_SP_DWAIT: cmd_o.div_store = stat_i.div_done;
      ptint_pkg::S_SP_WR: begin
        cmd_o.we_rec      = 1'b1;
        cmd_o.we_spawn    = 1'b1;
        cmd_o.cnt_inc     = 1'b1;
        cmd_o.emit        = 1'b1;
        cmd_o.emit_status = ptint_pkg::ST_DONE;
      end
      ptint_pkg::S_TK_FACC: begin
        cmd_o.acc    = 1'b1;
        cmd_o.op_inc = 1'b1;
        cmd_o.i_clr  = (stat_i.op == ptint_pkg::OP_FY);
      end
      ptint_pkg::S_TK_SCAN: ;
      ptint_pkg::S_TK_SWAIT: begin
        cmd_o.cnt_dec = stat_i.rd_neg;
        cmd_o.i_inc   = !stat_i.rd_neg;
      end
      ptint_pkg::S_TK_MRD:   cmd_o.rd_cnt = 1'b1;
      ptint_pkg::S_TK_MWAIT: begin
        cmd_o.rd_cnt  = 1'b1;
        cmd_o.we_move = 1'b1;
      end
      ptint_pkg::S_TK_PICK: begin
        cmd_o.i_clr       = 1'b1;
        cmd_o.emit        = stat_i.cnt_zero;
        cmd_o.emit_status = ptint_pkg::ST_EMPTY;
      end
      ptint_pkg::S_TK_RD:    ;
      ptint_pkg::S_TK_RWAIT: cmd_o.ld_rec = 1'b1;
      ptint_pkg::S_TK_PRE: begin
        cmd_o.tick_pre = 1'b1;
        cmd_o.op_ld    = 1'b1;
        cmd_o.op_val   = ptint_pkg::OP_VX;
      end
      ptint_pkg::S_TK_WB: begin
        cmd_o.we_rec      = 1'b1;
        cmd_o.emit        = 1'b1;
        cmd_o.emit_status = ptint_pkg::ST_REC;
        cmd_o.i_inc       = 1'b1;
      end
      default: ;
    endcase
  end

  assign busy_o = (state_q != ptint_pkg::S_IDLE);

endmodule

### rtl/core/particle_table_integrator.sv
// Top level of the particle table integrator: APB force registers, controller, datapath.
// Uses ptint_pkg, ptint_ctrl, ptint_dp.
//
// Holds up to 64 particles in one RAM row each and runs one command per item
// (start_i while busy_o is low): spawn, tick or clear. Spawn and clear answer
// with one beat; a tick answers with one beat per live particle, or one "empty"
// beat, the final beat flagged by last_o. Each beat is on the result ports for
// exactly one cycle under res_valid_o and must be taken then: the block never
// waits for the receiver. Spawn is set by the serial divider that forms the
// five rate quotients one bit a cycle, one after another. Tick runs a setup
// (dispatch and the two force products), a scan that keeps live particles and
// removes expired ones, then the update of each live particle, set by the
// single shared multiplier that forms the seven products of each particle one
// after another. The RAM needs no clearing pass: only rows below the live
// count are ever read. force_x/force_y sit at byte addresses 0 and 4 and
// should only be written while busy_o is low.
module particle_table_integrator (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command channel
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         mode_i,
  input  logic signed [23:0] start_x_i,
  input  logic signed [23:0] start_y_i,
  input  logic [15:0]        lifetime_i,
  input  logic [8:0]         heading_degrees_i,
  input  logic [15:0]        launch_speed_i,
  input  logic [15:0]        size_start_i,
  input  logic [15:0]        size_finish_i,
  input  logic [31:0]        rgba_start_i,
  input  logic [31:0]        rgba_finish_i,
  input  logic [15:0]        time_step_i,
  // result channel
  output logic               res_valid_o,
  output logic [1:0]         status_o,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic [7:0]         out_size_o,
  output logic [31:0]        out_rgba_o,
  output logic               last_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic signed [15:0] force_x_q, force_y_q;
  logic               cfg_wr;

  ptint_pkg::ctrl_cmd_t cmd;
  ptint_pkg::dp_stat_t  stat;

  // register write lands on the access beat; paddr[2] picks the word
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_x_q <= '0;
      force_y_q <= '0;
    end else if (cfg_wr) begin
      if (paddr[2]) force_y_q <= pwdata[15:0];
      else force_x_q <= pwdata[15:0];
    end
  end

  assign prdata = paddr[2] ? 32'(force_y_q) : 32'(force_x_q);

  ptint_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i,
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o
  );

  ptint_dp u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .stat_o     (stat),
    .mode_i,
    .start_x_i,
    .start_y_i,
    .lifetime_i,
    .heading_degrees_i,
    .launch_speed_i,
    .size_start_i,
    .size_finish_i,
    .rgba_start_i,
    .rgba_finish_i,
    .time_step_i,
    .force_x_i  (force_x_q),
    .force_y_i  (force_y_q),
    .res_valid_o,
    .status_o,
    .out_x_o,
    .out_y_o,
    .out_size_o,
    .out_rgba_o,
    .last_o
  );

endmodule

### rtl/core/ptint_checker.sv
// Port-level checks of the particle table integrator, bound to the top level.
// Uses ptint_pkg status codes.
module ptint_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               res_valid_o,
  input logic [1:0]         status_o,
  input logic signed [15:0] out_x_o,
  input logic [7:0]         out_size_o,
  input logic [31:0]        out_rgba_o,
  input logic               last_o,
  input logic               pready
);

  // an accepted command keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accept did not raise busy");

  // only particle records can be followed by more beats
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && status_o != ptint_pkg::ST_REC) |-> last_o)
    else $error("non-record beat without last");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && status_o != ptint_pkg::ST_REC) |->
      (out_x_o == '0 && out_size_o == '0 && out_rgba_o == '0))
    else $error("non-record beat carries particle data");

  // more records pending keep the command open
  a_stream_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !last_o) |-> busy_o) else $error("idle mid stream");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind particle_table_integrator ptint_checker u_ptint_checker (.*);
